FILE: sv/sjs_pkg.sv
// Package for the scan jump segmentation block: sizes, widths and state codes.
// No dependencies; imported by sjs_divider and scan_jump_segmentation.
`default_nettype none
package sjs_pkg;

    // scan geometry
    localparam int SCAN_POINTS  = 360;
    localparam int MAX_CLUSTERS = 100;

    // fixed field widths
    localparam int DIST_W    = 14;
    localparam int OSLOT_W   = 7;
    localparam int OANGLE_W  = 9;
    localparam int OCOUNT_W  = 9;

    // derived internal widths
    localparam int ANG_W  = $clog2(SCAN_POINTS);
    localparam int CNT_W  = $clog2(SCAN_POINTS + 1);
    localparam int SUM_W  = DIST_W + CNT_W;
    localparam int SLOT_W = $clog2(MAX_CLUSTERS);
    localparam int ITER_W = $clog2(SUM_W + 1);

    localparam logic [DIST_W-1:0] THRESHOLD_RESET = DIST_W'(100);

    // sequencer state codes
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

endpackage
`default_nettype wire

FILE: sv/sjs_divider.sv
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on sjs_pkg for the operand widths.
`default_nettype none
module sjs_divider
    import sjs_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [SUM_W-1:0]  i_dividend,
    input  wire logic [CNT_W-1:0]  i_divisor,
    output logic                   o_done,
    output logic [SUM_W-1:0]       o_quotient
);

    logic [SUM_W-1:0]  r_quo, n_quo;
    logic [CNT_W-1:0]  r_rem, n_rem;
    logic [CNT_W-1:0]  r_dsr;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic              r_done, n_done;
    logic [CNT_W:0]    trial;
    logic              ge;

    always_comb begin
        trial  = {r_rem, r_quo[SUM_W-1]};
        ge     = (trial >= {1'b0, r_dsr});
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_iter = r_iter;
        n_done = 1'b0;
        if (i_start) begin
            n_quo  = i_dividend;
            n_rem  = '0;
            n_iter = ITER_W'(SUM_W);
        end else if (r_iter != '0) begin
            // shift in the next dividend bit, subtract when it fits
            n_rem  = ge ? CNT_W'(trial - {1'b0, r_dsr}) : CNT_W'(trial);
            n_quo  = {r_quo[SUM_W-2:0], ge};
            n_iter = r_iter - ITER_W'(1);
            n_done = (r_iter == ITER_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iter <= '0;
            r_done <= 1'b0;
        end else begin
            r_iter <= n_iter;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_dsr <= i_divisor;
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

FILE: sv/scan_jump_segmentation.sv
// Top level of the range scan breakpoint segmentation block.
// Depends on sjs_pkg and sjs_divider.
//
// Usage:
//   Input channel (i_valid / o_ready / i_distance) carries one range sample per
//   transaction, in angle order, SCAN_POINTS samples per scan. Output channel
//   (o_valid / i_ready / o_segment_*) carries one closed segment per transaction.
//   A sample gives zero, one or two segments: a jump above the threshold closes the
//   open segment, and the last sample of the scan closes the final segment, flagged
//   by o_scan_last. When both happen, the jump segment comes out first. The user must
//   write the threshold (i_cfg_we / i_cfg_wdata) only while the block is idle; unenforced.
// Timing:
//   A sample that closes nothing leaves the sequencer idle. Each closed segment
//   goes through the bit-serial mean-distance divider, then its registered done
//   flag moves the sequencer to S_DONE, then the segment is loaded into the
//   output register; o_ready stays low from the accepting sample until its last
//   segment is loaded. o_ready is high only while the sequencer is idle.
// Reset:
//   Synchronous, active low: angle counter, segment state and slot go to zero,
//   the threshold goes to 100, the output register empties.
// Stall:
//   A finished segment waits in the divider until the output register is free;
//   the output register holds its transaction until i_ready is seen.
`default_nettype none
module scan_jump_segmentation
    import sjs_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [DIST_W-1:0]   i_cfg_wdata,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [DIST_W-1:0]   i_distance,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [OSLOT_W-1:0]       o_segment_slot,
    output logic [OANGLE_W-1:0]      o_mean_angle,
    output logic [DIST_W-1:0]        o_mean_distance,
    output logic [OCOUNT_W-1:0]      o_sample_count,
    output logic                     o_scan_last
);

    localparam logic [ANG_W-1:0]  LAST_ANGLE = ANG_W'(SCAN_POINTS - 1);
    localparam logic [SLOT_W-1:0] SLOT_MAX   = SLOT_W'(MAX_CLUSTERS - 1);

    // segment tracking state
    logic [DIST_W-1:0] r_thr;
    logic [ANG_W-1:0]  r_angle, n_angle;
    logic [ANG_W-1:0]  r_start, n_start;
    logic [SUM_W-1:0]  r_sum,   n_sum;
    logic [DIST_W-1:0] r_prev,  n_prev;
    logic [SLOT_W-1:0] r_slot,  n_slot;

    // sequencer
    logic [1:0] r_state, n_state;
    logic       r_pend,  n_pend;

    // segment being reported
    logic [SLOT_W-1:0] r_job_slot, n_job_slot;
    logic [ANG_W-1:0]  r_job_start, n_job_start;
    logic [ANG_W-1:0]  r_job_last, n_job_last;
    logic              r_job_flag, n_job_flag;
    logic [SUM_W-1:0]  job_sum;
    logic              job_load;
    logic [CNT_W-1:0]  load_count;

    // output register
    logic                r_o_valid, n_o_valid;
    logic [OSLOT_W-1:0]  r_o_slot;
    logic [OANGLE_W-1:0] r_o_angle;
    logic [DIST_W-1:0]   r_o_dist;
    logic [OCOUNT_W-1:0] r_o_count;
    logic                r_o_last;
    logic                out_load;

    // per-sample decode
    logic              accept;
    logic              first;
    logic              brk;
    logic              endf;
    logic [DIST_W-1:0] diff;

    // output field formatting
    logic [CNT_W-1:0]  job_count;
    logic [ANG_W:0]    angle_sum;
    logic [31:0]       slot_wide;
    logic [31:0]       angle_wide;
    logic [31:0]       count_wide;

    logic              div_done;
    logic [SUM_W-1:0]  div_quo;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        first = (r_angle == '0);
        endf  = (r_angle == LAST_ANGLE);
        diff  = (i_distance > r_prev) ? (i_distance - r_prev) : (r_prev - i_distance);
        brk   = !first && (diff > r_thr);
    end

    always_comb begin
        n_angle     = r_angle;
        n_start     = r_start;
        n_sum       = r_sum;
        n_prev      = r_prev;
        n_slot      = r_slot;
        n_state     = r_state;
        n_pend      = r_pend;
        n_job_slot  = r_job_slot;
        n_job_start = r_job_start;
        n_job_last  = r_job_last;
        n_job_flag  = r_job_flag;
        job_sum     = r_sum;
        job_load    = 1'b0;
        out_load    = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_prev  = i_distance;
                    n_angle = endf ? '0 : r_angle + ANG_W'(1);
                    if (first) begin
                        // restart segment, sum and slot on the first sample of a scan
                        n_start = '0;
                        n_sum   = SUM_W'(i_distance);
                        n_slot  = '0;
                    end else if (brk) begin
                        n_start = r_angle;
                        n_sum   = SUM_W'(i_distance);
                        n_slot  = (r_slot < SLOT_MAX) ? r_slot + SLOT_W'(1) : r_slot;
                    end else begin
                        n_sum   = r_sum + SUM_W'(i_distance);
                    end

                    if (brk) begin
                        // report the closed segment from the old state
                        n_job_slot  = r_slot;
                        n_job_start = r_start;
                        n_job_last  = r_angle - ANG_W'(1);
                        n_job_flag  = 1'b0;
                        job_sum     = r_sum;
                        job_load    = 1'b1;
                        n_pend      = endf;
                        n_state     = S_DIV;
                    end else if (endf) begin
                        n_job_slot  = n_slot;
                        n_job_start = n_start;
                        n_job_last  = LAST_ANGLE;
                        n_job_flag  = 1'b1;
                        job_sum     = n_sum;
                        job_load    = 1'b1;
                        n_pend      = 1'b0;
                        n_state     = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_o_valid || i_ready) begin
                    out_load = 1'b1;
                    if (r_pend) begin
                        // scan end after a break: report the final segment next
                        n_job_slot  = r_slot;
                        n_job_start = r_start;
                        n_job_last  = LAST_ANGLE;
                        n_job_flag  = 1'b1;
                        job_sum     = r_sum;
                        job_load    = 1'b1;
                        n_pend      = 1'b0;
                        n_state     = S_DIV;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign load_count = CNT_W'(n_job_last) - CNT_W'(n_job_start) + CNT_W'(1);

    sjs_divider u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (job_load),
        .i_dividend (job_sum),
        .i_divisor  (load_count),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // fields of the segment held in the job registers
    always_comb begin
        job_count  = CNT_W'(r_job_last) - CNT_W'(r_job_start) + CNT_W'(1);
        angle_sum  = {1'b0, r_job_start} + {1'b0, r_job_last};
        slot_wide  = 32'(r_job_slot);
        angle_wide = 32'(angle_sum[ANG_W:1]);
        count_wide = 32'(job_count);
        n_o_valid  = out_load ? 1'b1 : (r_o_valid && !i_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr     <= THRESHOLD_RESET;
            r_angle   <= '0;
            r_start   <= '0;
            r_sum     <= '0;
            r_prev    <= '0;
            r_slot    <= '0;
            r_state   <= S_IDLE;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            r_angle   <= n_angle;
            r_start   <= n_start;
            r_sum     <= n_sum;
            r_prev    <= n_prev;
            r_slot    <= n_slot;
            r_state   <= n_state;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job_slot  <= n_job_slot;
        r_job_start <= n_job_start;
        r_job_last  <= n_job_last;
        r_job_flag  <= n_job_flag;
        if (out_load) begin
            r_o_slot  <= slot_wide[OSLOT_W-1:0];
            r_o_angle <= angle_wide[OANGLE_W-1:0];
            r_o_dist  <= div_quo[DIST_W-1:0];
            r_o_count <= count_wide[OCOUNT_W-1:0];
            r_o_last  <= r_job_flag;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_segment_slot  = r_o_slot;
    assign o_mean_angle    = r_o_angle;
    assign o_mean_distance = r_o_dist;
    assign o_sample_count  = r_o_count;
    assign o_scan_last     = r_o_last;

endmodule
`default_nettype wire

FILE: bench/sjs_segment_checker.sv
// Segment checker for the scan jump segmentation block: predicts closed segments
// from accepted range samples and compares them with the output transactions.
// Depends on sjs_pkg for field widths and scan geometry.
`timescale 1ns / 100ps
module sjs_segment_checker
    import sjs_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [DIST_W-1:0]   i_cfg_wdata,
    input  wire logic                i_in_valid,
    input  wire logic                i_in_ready,
    input  wire logic [DIST_W-1:0]   i_distance,
    input  wire logic                i_out_valid,
    input  wire logic                i_out_ready,
    input  wire logic [OSLOT_W-1:0]  i_segment_slot,
    input  wire logic [OANGLE_W-1:0] i_mean_angle,
    input  wire logic [DIST_W-1:0]   i_mean_distance,
    input  wire logic [OCOUNT_W-1:0] i_sample_count,
    input  wire logic                i_scan_last,
    output int                       o_fail_count,
    output int                       o_pending
);

    localparam int PRINT_LIMIT = 40;

    typedef struct packed {
        logic [OSLOT_W-1:0]  slot;
        logic [OANGLE_W-1:0] angle;
        logic [DIST_W-1:0]   mean_dist;
        logic [OCOUNT_W-1:0] count;
        logic                last;
    } segment_t;

    segment_t expected_segments[$];

    // predicted block state
    logic [DIST_W-1:0] jump_limit;
    int                scan_angle;
    int                seg_first;
    int                seg_sum;
    logic [DIST_W-1:0] last_dist;
    int                seg_slot;
    int                fail_count;

    initial begin
        fail_count = 0;
    end

    task automatic report_error(input string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("%0t sjs_segment_checker: %s", $realtime, msg);
    endtask

    task automatic close_segment(input int last_angle, input logic is_last);
        segment_t seg;
        int       count;
        count         = last_angle - seg_first + 1;
        seg.slot      = OSLOT_W'(seg_slot);
        seg.angle     = OANGLE_W'((seg_first + last_angle) / 2);
        seg.mean_dist = DIST_W'(seg_sum / count);
        seg.count     = OCOUNT_W'(count);
        seg.last      = is_last;
        expected_segments.push_back(seg);
    endtask

    // advance the scan by one sample and queue the segments it closes
    task automatic advance_scan(input logic [DIST_W-1:0] d);
        int a;
        int diff;
        a = scan_angle;
        if (a >= SCAN_POINTS)
            a = 0;
        if (a == 0) begin
            // first sample of a scan: restart without comparing
            seg_first = 0;
            seg_sum   = 0;
            seg_slot  = 0;
        end else begin
            diff = (d > last_dist) ? int'(d - last_dist) : int'(last_dist - d);
            if (diff > int'(jump_limit)) begin
                close_segment(a - 1, 1'b0);
                seg_first = a;
                seg_sum   = 0;
                if (seg_slot < MAX_CLUSTERS - 1)
                    seg_slot++;
            end
        end
        seg_sum   = seg_sum + int'(d);
        last_dist = d;
        if (a == SCAN_POINTS - 1) begin
            close_segment(a, 1'b1);
            scan_angle = 0;
        end else begin
            scan_angle = a + 1;
        end
    endtask

    task automatic check_segment();
        segment_t want;
        if (expected_segments.size() == 0) begin
            report_error($sformatf("segment with no expectation: slot %0d angle %0d dist %0d",
                                   i_segment_slot, i_mean_angle, i_mean_distance));
            return;
        end
        want = expected_segments.pop_front();
        if (i_segment_slot !== want.slot)
            report_error($sformatf("segment_slot got %0d expected %0d",
                                   i_segment_slot, want.slot));
        if (i_mean_angle !== want.angle)
            report_error($sformatf("mean_angle got %0d expected %0d",
                                   i_mean_angle, want.angle));
        if (i_mean_distance !== want.mean_dist)
            report_error($sformatf("mean_distance got %0d expected %0d",
                                   i_mean_distance, want.mean_dist));
        if (i_sample_count !== want.count)
            report_error($sformatf("sample_count got %0d expected %0d",
                                   i_sample_count, want.count));
        if (i_scan_last !== want.last)
            report_error($sformatf("scan_last got %0d expected %0d",
                                   i_scan_last, want.last));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            jump_limit = THRESHOLD_RESET;
            scan_angle = 0;
            seg_first  = 0;
            seg_sum    = 0;
            last_dist  = '0;
            seg_slot   = 0;
            expected_segments.delete();
        end else begin
            if (i_cfg_we)
                jump_limit = i_cfg_wdata;
            // check before predicting: a sample never yields a result on its own edge
            if (i_out_valid && i_out_ready)
                check_segment();
            if (i_in_valid && i_in_ready)
                advance_scan(i_distance);
        end
        o_pending    <= expected_segments.size();
        o_fail_count <= fail_count;
    end

endmodule

FILE: bench/scan_jump_segmentation_test.sv
// Testbench top for scan_jump_segmentation: drives range samples and threshold
// writes, idles both channels at random and gives the verdict.
// Depends on sjs_pkg, scan_jump_segmentation and sjs_segment_checker.
`timescale 1ns / 100ps
module scan_jump_segmentation_test;
    import sjs_pkg::*;

    localparam int DIST_MAX     = (1 << DIST_W) - 1;
    localparam int PHASE_ITEMS  = 305;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off to back up the block
    localparam int DRAIN_CYCLES = 60;    // covers two segments through the divider
    localparam int STALL_LIMIT  = 5000;  // cycles without any transaction

    logic                i_clk       = 1'b0;
    logic                i_rst_n     = 1'b0;
    logic                i_cfg_we    = 1'b0;
    logic [DIST_W-1:0]   i_cfg_wdata = '0;
    logic                i_valid     = 1'b0;
    logic [DIST_W-1:0]   i_distance  = '0;
    logic                i_ready     = 1'b0;
    logic                o_ready;
    logic                o_valid;
    logic [OSLOT_W-1:0]  o_segment_slot;
    logic [OANGLE_W-1:0] o_mean_angle;
    logic [DIST_W-1:0]   o_mean_distance;
    logic [OCOUNT_W-1:0] o_sample_count;
    logic                o_scan_last;

    int fail_count;
    int pending;

    // shared between the sample driver and the receiver
    bit idle_on      = 1'b1;
    bit hold_request = 1'b0;

    // sample generator state: runs of similar range with occasional stray samples
    int level;
    int run_left;
    int max_run;
    int noise_amp;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    scan_jump_segmentation u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_distance      (i_distance),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_segment_slot  (o_segment_slot),
        .o_mean_angle    (o_mean_angle),
        .o_mean_distance (o_mean_distance),
        .o_sample_count  (o_sample_count),
        .o_scan_last     (o_scan_last)
    );

    sjs_segment_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_valid),
        .i_in_ready      (o_ready),
        .i_distance      (i_distance),
        .i_out_valid     (o_valid),
        .i_out_ready     (i_ready),
        .i_segment_slot  (o_segment_slot),
        .i_mean_angle    (o_mean_angle),
        .i_mean_distance (o_mean_distance),
        .i_sample_count  (o_sample_count),
        .i_scan_last     (o_scan_last),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    // Watchdog: end the run when no transaction moves on either channel for too long.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("scan_jump_segmentation_test: errors");
            $finish;
        end
    end

    // Receiver: drop i_ready in random bursts while idling is on, and hold it low
    // for a long stretch when asked, so the block fills up and stalls its input.
    initial begin
        int burst;
        wait (i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                i_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
                i_ready <= 1'b1;
            end else if (idle_on && $urandom_range(0, 9) == 0) begin
                burst = $urandom_range(1, 19);
                i_ready <= 1'b0;
                repeat (burst) @(negedge i_clk);
                i_ready <= 1'b1;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // Offer one sample. Entered and left just after a falling edge; valid stays
    // high into the next call unless an idle burst drops it first.
    task automatic offer_sample(input logic [DIST_W-1:0] d);
        int gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_distance <= d;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every expected segment plus the divider latency,
    // then write the threshold while the block is idle.
    task automatic settle_and_write(input logic [DIST_W-1:0] thr);
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= thr;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // Next sample: mostly runs around a level with noise inside the threshold,
    // some stray full-range samples to break runs.
    task automatic next_distance(output logic [DIST_W-1:0] d);
        int v;
        if ($urandom_range(0, 9) == 0) begin
            d = DIST_W'($urandom);
        end else begin
            if (run_left == 0) begin
                case ($urandom_range(0, 7))
                    0: begin
                        level = 0;
                    end
                    1: begin
                        level = DIST_MAX;
                    end
                    default: begin
                        level = int'($urandom_range(0, DIST_MAX));
                    end
                endcase
                run_left = int'($urandom_range(1, max_run));
            end
            run_left--;
            v = level + int'($urandom_range(0, 2 * noise_amp)) - noise_amp;
            if (v < 0)
                v = 0;
            if (v > DIST_MAX)
                v = DIST_MAX;
            d = DIST_W'(v);
        end
    endtask

    task automatic run_phase(input int thr, input int run_max, input bit pressure);
        logic [DIST_W-1:0] d;
        settle_and_write(DIST_W'(thr));
        max_run   = run_max;
        noise_amp = thr / 2;
        run_left  = 0;
        if (pressure)
            hold_request = 1'b1;
        repeat (PHASE_ITEMS) begin
            next_distance(d);
            offer_sample(d);
        end
    endtask

    initial begin
        int unsigned probe[$];

        // hold reset low, then release it on a falling edge
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset threshold of 100: first sample of the scan, full-range jumps,
        // a jump of exactly the threshold (no break) and one just above it.
        probe = '{0, 16383, 16383, 0, 0, 100, 201, 101, 0, 16383, 16283, 16282};
        foreach (probe[i])
            offer_sample(DIST_W'(probe[i]));

        // zero threshold: equal samples stay together, any change breaks
        settle_and_write('0);
        probe = '{5, 5, 6, 6};
        foreach (probe[i])
            offer_sample(DIST_W'(probe[i]));

        // full threshold: even a full-range jump never breaks
        settle_and_write(DIST_W'(DIST_MAX));
        probe = '{0, 16383, 0, 16383};
        foreach (probe[i])
            offer_sample(DIST_W'(probe[i]));

        // Random phases. The first one breaks on most samples, so the
        // slot saturates well within the current scan.
        run_phase(0, 2, 1'b0);
        run_phase(DIST_MAX, 40, 1'b0);
        run_phase(int'($urandom_range(1, 300)), 30, 1'b0);
        run_phase(0, 4, 1'b1);
        run_phase(int'($urandom_range(0, DIST_MAX)), 40, 1'b0);
        idle_on = 1'b0;
        run_phase(int'($urandom_range(20, 2000)), 25, 1'b0);

        // drain: wait for every expected segment, then a little longer for strays
        i_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (fail_count == 0 && pending == 0)
            $display("scan_jump_segmentation_test: clean");
        else
            $display("scan_jump_segmentation_test: errors");
        $finish;
    end

endmodule
